### hdl/fwt_pkg.sv
package fwt_pkg;

	localparam int MIN_WINDOW_DEF = 32;
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic [16:0] HALF_Q16 = 17'h08000;

	typedef enum logic [2:0] {
		REG_ORIENTATION = 3'd0,
		REG_CROP_LEFT   = 3'd1,
		REG_CROP_TOP    = 3'd2,
		REG_CROP_WIDE   = 3'd3,
		REG_CROP_TALL   = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ORIENT_IDENTITY       = 4'd1,
		ORIENT_MIRROR_X       = 4'd2,
		ORIENT_ROTATE_180     = 4'd3,
		ORIENT_MIRROR_Y       = 4'd4,
		ORIENT_TRANSPOSE      = 4'd5,
		ORIENT_ROTATE_270     = 4'd6,
		ORIENT_ANTI_TRANSPOSE = 4'd7,
		ORIENT_ROTATE_90      = 4'd8
	} orient_t;

	typedef struct packed {
		logic [3:0]  orientation;
		logic [15:0] crop_left;
		logic [15:0] crop_top;
		logic [15:0] crop_wide;
		logic [15:0] crop_tall;
	} cfg_t;

	typedef struct packed {
		logic [16:0] tap_x;
		logic [16:0] tap_y;
		logic [15:0] size_fraction;
	} tap_t;

	typedef struct packed {
		logic [16:0] win_left;
		logic [16:0] win_top;
		logic [15:0] win_width;
		logic [15:0] win_height;
	} win_t;

endpackage

### hdl/fwt_regs.sv
module fwt_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fwt_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [fwt_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [fwt_pkg::CFG_DATA_W-1:0]      prdata,
	output fwt_pkg::cfg_t                       cfg
);

	fwt_pkg::cfg_t    cfg_q;
	fwt_pkg::reg_idx_t reg_idx;
	logic             wr_en;

	assign reg_idx = fwt_pkg::reg_idx_t'(paddr[fwt_pkg::CFG_ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.orientation <= fwt_pkg::ORIENT_IDENTITY;
			cfg_q.crop_left <= 16'd0;
			cfg_q.crop_top <= 16'd0;
			cfg_q.crop_wide <= 16'd1;
			cfg_q.crop_tall <= 16'd1;
		end else if (wr_en) begin
			unique case (reg_idx)
				fwt_pkg::REG_ORIENTATION: cfg_q.orientation <= pwdata[3:0];
				fwt_pkg::REG_CROP_LEFT: cfg_q.crop_left <= pwdata[15:0];
				fwt_pkg::REG_CROP_TOP: cfg_q.crop_top <= pwdata[15:0];
				fwt_pkg::REG_CROP_WIDE: cfg_q.crop_wide <= pwdata[15:0];
				fwt_pkg::REG_CROP_TALL: cfg_q.crop_tall <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			fwt_pkg::REG_ORIENTATION: prdata[3:0] = cfg_q.orientation;
			fwt_pkg::REG_CROP_LEFT: prdata[15:0] = cfg_q.crop_left;
			fwt_pkg::REG_CROP_TOP: prdata[15:0] = cfg_q.crop_top;
			fwt_pkg::REG_CROP_WIDE: prdata[15:0] = cfg_q.crop_wide;
			fwt_pkg::REG_CROP_TALL: prdata[15:0] = cfg_q.crop_tall;
			default: prdata = '0;
		endcase
	end

endmodule

### hdl/fwt_axis.sv
module fwt_axis #(
	parameter int MIN_WINDOW = fwt_pkg::MIN_WINDOW_DEF
) (
	input  logic        clk,
	input  logic        en_s2,
	input  logic        en_s3,
	input  logic        en_out,
	input  logic [16:0] pos,
	input  logic [15:0] frac,
	input  logic [15:0] crop,
	input  logic [15:0] offset,
	output logic [16:0] win_lo_q,
	output logic [15:0] win_size_q
);

	localparam logic [16:0] MIN_SIZE = 17'(MIN_WINDOW);
	localparam logic [16:0] HALF_ROUND = fwt_pkg::HALF_Q16;

	logic [31:0] size_prod;
	logic [32:0] size_sum;
	logic [32:0] cen_prod;
	logic [32:0] cen_sum;
	logic [16:0] size_rnd_s2;
	logic [16:0] cen_s2;

	logic [16:0] size_lo;
	logic [16:0] size_clamped;
	logic [15:0] size_s3;
	logic [16:0] cen_s3;

	logic [15:0] half;
	logic [15:0] lim;
	logic [16:0] diff;
	logic [16:0] rel;

	assign size_prod = 32'(crop) * 32'(frac);
	assign size_sum = 33'(size_prod) + 33'(HALF_ROUND);
	assign cen_prod = 33'(pos) * 33'(crop - 16'd1);
	assign cen_sum = cen_prod + 33'(HALF_ROUND);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			size_rnd_s2 <= size_sum[32:16];
			cen_s2 <= cen_sum[32:16];
		end
	end

	always_comb begin
		size_lo = (size_rnd_s2 < MIN_SIZE) ? MIN_SIZE : size_rnd_s2;
		size_clamped = (size_lo > 17'(crop)) ? 17'(crop) : size_lo;
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			size_s3 <= size_clamped[15:0];
			cen_s3 <= cen_s2;
		end
	end

	always_comb begin
		half = {1'b0, size_s3[15:1]};
		lim = crop - size_s3;
		diff = cen_s3 - 17'(half);
		if (cen_s3 < 17'(half)) begin
			rel = 17'd0;
		end else if (diff > 17'(lim)) begin
			rel = 17'(lim);
		end else begin
			rel = diff;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			win_lo_q <= 17'(offset) + rel;
			win_size_q <= size_s3;
		end
	end

endmodule

### hdl/focus_window_from_tap.sv
// Turns a tap point on the displayed image into an autofocus window in sensor crop
// coordinates. One transaction is accepted per clock while the output is taken, and its
// window passes through the input register, multiply stage, size clamp stage and result
// register in that order; a stalled result register backs up the stages behind it one by
// one, so throughput stays one transaction per cycle while the output is taken. Crop and
// orientation registers may only be written while no transaction is in flight.
module focus_window_from_tap #(
	parameter int MIN_WINDOW = fwt_pkg::MIN_WINDOW_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tap_valid,
	output logic                           tap_ready,
	input  fwt_pkg::tap_t                  tap,
	output logic                           win_valid,
	input  logic                           win_ready,
	output fwt_pkg::win_t                  win,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fwt_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [fwt_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [fwt_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);

	fwt_pkg::cfg_t cfg;
	fwt_pkg::tap_t tap_s1;

	logic v1_q, v2_q, v3_q, vo_q;
	logic adv1, adv2, adv3, adv_o;
	logic [15:0] crop_w_eff, crop_h_eff;
	logic [16:0] tx, ty, px, py;

	assign pready = 1'b1;

	fwt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign crop_w_eff = (cfg.crop_wide == 16'd0) ? 16'd1 : cfg.crop_wide;
	assign crop_h_eff = (cfg.crop_tall == 16'd0) ? 16'd1 : cfg.crop_tall;

	assign adv_o = !vo_q || win_ready;
	assign adv3 = !v3_q || adv_o;
	assign adv2 = !v2_q || adv3;
	assign adv1 = !v1_q || adv2;
	assign tap_ready = adv1;
	assign win_valid = vo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (adv1) v1_q <= tap_valid;
			if (adv2) v2_q <= v1_q;
			if (adv3) v3_q <= v2_q;
			if (adv_o) vo_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (tap_valid && adv1) begin
			tap_s1 <= tap;
		end
	end

	always_comb begin
		tx = (tap_s1.tap_x > fwt_pkg::ONE_Q16) ? fwt_pkg::ONE_Q16 : tap_s1.tap_x;
		ty = (tap_s1.tap_y > fwt_pkg::ONE_Q16) ? fwt_pkg::ONE_Q16 : tap_s1.tap_y;
		unique case (cfg.orientation)
			fwt_pkg::ORIENT_MIRROR_X: begin
				px = fwt_pkg::ONE_Q16 - tx;
				py = ty;
			end
			fwt_pkg::ORIENT_ROTATE_180: begin
				px = fwt_pkg::ONE_Q16 - tx;
				py = fwt_pkg::ONE_Q16 - ty;
			end
			fwt_pkg::ORIENT_MIRROR_Y: begin
				px = tx;
				py = fwt_pkg::ONE_Q16 - ty;
			end
			fwt_pkg::ORIENT_TRANSPOSE: begin
				px = ty;
				py = tx;
			end
			fwt_pkg::ORIENT_ROTATE_270: begin
				px = fwt_pkg::ONE_Q16 - ty;
				py = tx;
			end
			fwt_pkg::ORIENT_ANTI_TRANSPOSE: begin
				px = fwt_pkg::ONE_Q16 - ty;
				py = fwt_pkg::ONE_Q16 - tx;
			end
			fwt_pkg::ORIENT_ROTATE_90: begin
				px = ty;
				py = fwt_pkg::ONE_Q16 - tx;
			end
			default: begin
				px = tx;
				py = ty;
			end
		endcase
	end

	fwt_axis #(.MIN_WINDOW(MIN_WINDOW)) u_axis_x (
		.clk        (clk),
		.en_s2      (adv2 && v1_q),
		.en_s3      (adv3 && v2_q),
		.en_out     (adv_o && v3_q),
		.pos        (px),
		.frac       (tap_s1.size_fraction),
		.crop       (crop_w_eff),
		.offset     (cfg.crop_left),
		.win_lo_q   (win.win_left),
		.win_size_q (win.win_width)
	);

	fwt_axis #(.MIN_WINDOW(MIN_WINDOW)) u_axis_y (
		.clk        (clk),
		.en_s2      (adv2 && v1_q),
		.en_s3      (adv3 && v2_q),
		.en_out     (adv_o && v3_q),
		.pos        (py),
		.frac       (tap_s1.size_fraction),
		.crop       (crop_h_eff),
		.offset     (cfg.crop_top),
		.win_lo_q   (win.win_top),
		.win_size_q (win.win_height)
	);

	// An empty result register must let the whole pipeline move.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!vo_q |-> tap_ready)
		else $error("input stalled while the result register is empty");

	a_size_in_crop: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid |-> (win.win_width <= crop_w_eff) && (win.win_height <= crop_h_eff))
		else $error("window larger than the crop");

	a_size_floor: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid |-> (win.win_width >= 16'(MIN_WINDOW) || win.win_width == crop_w_eff))
		else $error("window width below the minimum");

	a_left_inside: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid |-> (win.win_left >= 17'(cfg.crop_left))
			&& (18'(win.win_left) + 18'(win.win_width)
				<= 18'(cfg.crop_left) + 18'(crop_w_eff)))
		else $error("window leaves the crop horizontally");

	a_top_inside: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid |-> (win.win_top >= 17'(cfg.crop_top))
			&& (18'(win.win_top) + 18'(win.win_height)
				<= 18'(cfg.crop_top) + 18'(crop_h_eff)))
		else $error("window leaves the crop vertically");

endmodule
